// ===== design/gket_pkg.sv =====
// Package: shared constants and the saturating accumulate function for the group kinetic energy tensor block
`timescale 1ns / 1ps
`default_nettype none
package gket_pkg;
    localparam int MaxGroupsDefault = 8;
    localparam int AccW = 48;
    localparam int VelW = 24;
    localparam int MassW = 24;
    localparam int ShiftK = 25;
    localparam int NumElem = 9;
    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 4;
    localparam logic [CfgIdxW-1:0] CFG_GROUP_COUNT = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_MASS_PERT = 1'd1;
    localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};

    // floor(p / 2^25) saturated, then saturating add
    function automatic logic signed [AccW-1:0] sat_acc(
        input logic signed [AccW-1:0] acc,
        input logic signed [97:0] prod
    );
        logic signed [72:0] term;
        logic signed [AccW-1:0] t;
        logic signed [AccW:0] s;
        begin
            term = prod[97:ShiftK];
            if (term > 73'sd140737488355327)
                t = ACC_MAX;
            else if (term < -73'sd140737488355328)
                t = ACC_MIN;
            else
                t = term[AccW-1:0];
            s = {acc[AccW-1], acc} + {t[AccW-1], t};
            if (s[AccW] != s[AccW-1])
                sat_acc = s[AccW] ? ACC_MIN : ACC_MAX;
            else
                sat_acc = s[AccW-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== design/gket_mac.sv =====
// Product unit: velocity products in one stage, mass products split over the next two
`timescale 1ns / 1ps
`default_nettype none
module gket_mac
(
    input  wire                                  clk,
    input  wire                                  en,
    input  wire signed [gket_pkg::VelW-1:0]      va,
    input  wire signed [gket_pkg::VelW-1:0]      vb,
    input  wire signed [gket_pkg::MassW:0]       mass,
    output logic signed [97:0]                   prod
);
    logic signed [47:0] vv_reg;
    logic signed [gket_pkg::MassW:0] m_reg;
    logic signed [49:0] lo_reg;
    logic signed [48:0] hi_reg;
    logic en_reg;
    logic en2_reg;

    always_ff @(posedge clk)
    begin
        en_reg <= en;
        en2_reg <= en_reg;
        if (en)
        begin
            vv_reg <= va * vb;
            m_reg <= mass;
        end
        // low and high halves of the velocity product, each at most 25 by 25 bits
        if (en_reg)
        begin
            lo_reg <= m_reg * $signed({1'b0, vv_reg[23:0]});
            hi_reg <= m_reg * $signed(vv_reg[47:24]);
        end
        if (en2_reg)
            prod <= (98'(hi_reg) <<< 24) + 98'(lo_reg);
    end
endmodule
`default_nettype wire

// ===== design/group_kinetic_energy_tensor.sv =====
// Top level: per-group kinetic energy tensor accumulator with stream ports
`timescale 1ns / 1ps
`default_nettype none
// Adds 0.5*m*v_m*v_d to the 3x3 tensor of each atom's group and, for flagged atoms with
// mass perturbation on, 0.5*dm*|v|^2 to a derivative register; Q.16 sums saturate at
// 48 bits. An atom is accepted in the idle state; then steps issue its nine tensor terms
// and three |v|^2 terms one per cycle into a three-stage multiplier path and drain it,
// with a read-modify-write of the tensor memory (registered read). On the last atom each
// group in use then reads and clears its entries and offers its result, which is held
// while m_axis_tready is low; after the last result the entries of groups past the
// count are cleared, one per cycle, before the next item is taken. After reset the
// tensor memory is cleared entry by entry in the clear state, during which no item is
// taken.
module group_kinetic_energy_tensor #(
    parameter int MAX_GROUPS = gket_pkg::MaxGroupsDefault
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // group_index[2:0], atom_mass[26:3], vel_x[50:27], vel_y[74:51], vel_z[98:75],
    // is_perturbed[99], mass_state_a[123:100], mass_state_b[147:124], zeros
    input  wire  [151:0] s_axis_tdata,
    input  wire          s_axis_tlast,  // last_atom
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_group[2:0], t_xx..t_zz [434:3], energy_derivative[482:435], zeros
    output logic [487:0] m_axis_tdata,
    output logic         m_axis_tlast,  // last_result
    input  wire          cfg_we,
    input  wire  [gket_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire  [gket_pkg::CfgDataW-1:0] cfg_data
);
    localparam int Depth = MAX_GROUPS * gket_pkg::NumElem;
    localparam int AW = $clog2(Depth + 1);
    localparam int GW = $clog2(MAX_GROUPS + 1);
    localparam int AccW = gket_pkg::AccW;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_ACC   = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [AccW-1:0] mem [Depth];
    logic [3:0] gcount_reg;
    logic pert_reg;
    logic [151:0] item_reg;
    logic last_reg;
    logic [3:0] step_reg;
    logic [AW-1:0] addr_reg;
    logic [GW-1:0] grp_reg;
    logic [3:0] elem_reg;
    logic signed [AccW-1:0] deriv_reg;
    logic signed [97:0] dpart_reg;
    logic [AccW-1:0] rd_reg;
    logic [AccW-1:0] mem_q;
    logic [AccW-1:0] row_reg [9];
    logic [GW-1:0] eff;

    always_comb
    begin
        if (gcount_reg == 4'd0)
            eff = GW'(1);
        else if ({28'd0, gcount_reg} > 32'(MAX_GROUPS))
            eff = GW'(MAX_GROUPS);
        else
            eff = GW'(gcount_reg);
    end

    logic [2:0] g_in;
    logic signed [23:0] vel [3];
    logic signed [24:0] dm;
    logic [1:0] mi, di;
    logic signed [23:0] va, vb;
    logic signed [24:0] mass_op;
    logic mac_en;
    logic signed [97:0] prod;
    logic grp_ok;

    assign g_in = item_reg[2:0];
    assign vel[0] = item_reg[50:27];
    assign vel[1] = item_reg[74:51];
    assign vel[2] = item_reg[98:75];
    assign dm = $signed({1'b0, item_reg[147:124]}) - $signed({1'b0, item_reg[123:100]});
    assign grp_ok = 32'(g_in) < 32'(eff);

    // steps 0..8 tensor terms, 9..11 |v|^2 terms
    always_comb
    begin
        mi = 2'd0;
        di = 2'd0;
        mass_op = $signed({1'b0, item_reg[26:3]});
        priority if (step_reg < 4'd3)
            di = 2'(step_reg);
        else if (step_reg < 4'd6)
        begin
            mi = 2'd1;
            di = 2'(step_reg - 4'd3);
        end
        else if (step_reg < 4'd9)
        begin
            mi = 2'd2;
            di = 2'(step_reg - 4'd6);
        end
        else if (step_reg < 4'd12)
        begin
            mi = 2'(step_reg - 4'd9);
            di = mi;
            mass_op = dm;
        end
        else
        begin
            mi = 2'd0;
            di = 2'd0;
        end
        va = vel[mi];
        vb = vel[di];
    end
    assign mac_en = (state_reg == ST_ACC) && step_reg < 4'd12;

    gket_mac u_mac (.clk(clk), .en(mac_en), .va(va), .vb(vb), .mass(mass_op), .prod(prod));

    // pipeline tag: valid, derivative flag, memory address, three stages
    logic [2:0] tv;
    logic [2:0] td;
    logic [AW-1:0] ta [3];
    logic signed [AccW-1:0] upd;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv <= 3'b000;
        else
            tv <= {tv[1:0], mac_en && (step_reg >= 4'd9 || grp_ok)};
    end
    always_ff @(posedge clk)
    begin
        td <= {td[1:0], step_reg >= 4'd9};
        ta[0] <= AW'(32'(g_in) * 9 + 32'(step_reg));
        ta[1] <= ta[0];
        ta[2] <= ta[1];
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[ta[1] < AW'(Depth) ? ta[1] : AW'(0)];
    end
    // addresses in the pipe differ each cycle: no forwarding needed
    assign upd = gket_pkg::sat_acc($signed(rd_reg), prod);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR || (state_reg == ST_EMIT))
            mem[addr_reg] <= '0;
        else if (tv[2] && !td[2])
            mem[ta[2]] <= upd;
        if (state_reg == ST_EMIT && elem_reg != 4'd0)
            row_reg[elem_reg - 4'd1] <= mem_q;
    end

    always_ff @(posedge clk)
    begin
        mem_q <= mem[addr_reg < AW'(Depth) ? addr_reg : AW'(0)];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (addr_reg == AW'(Depth - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_ACC;
            ST_ACC:   if (step_reg == 4'd14) state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (elem_reg == 4'd9) state_next = ST_OUT;
            ST_OUT:
                if (m_axis_tready)
                begin
                    priority if (grp_reg + 1'b1 != eff)
                        state_next = ST_EMIT;
                    else if (addr_reg == AW'(Depth - 1))
                        state_next = ST_IDLE;
                    else
                        state_next = ST_CLEAR;
                end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tlast = (grp_reg + 1'b1 == eff);

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[2:0] = 3'(grp_reg);
        for (int e = 0; e < 9; e++)
            m_axis_tdata[3 + e*AccW +: AccW] = row_reg[e];
        m_axis_tdata[435 +: AccW] = deriv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            gcount_reg <= 4'd1;
            pert_reg <= 1'b0;
            step_reg <= '0;
            addr_reg <= '0;
            grp_reg <= '0;
            elem_reg <= '0;
            deriv_reg <= '0;
            dpart_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == gket_pkg::CFG_GROUP_COUNT)
                gcount_reg <= cfg_data;
            if (cfg_we && cfg_index == gket_pkg::CFG_MASS_PERT)
                pert_reg <= cfg_data[0];
            // |v|^2 terms summed unshifted, then one floor and one saturating add
            if (state_reg == ST_ACC && step_reg == 4'd12)
                dpart_reg <= prod;
            else if (state_reg == ST_ACC && step_reg == 4'd13)
                dpart_reg <= dpart_reg + prod;
            else if (state_reg == ST_ACC && step_reg == 4'd14 && pert_reg && item_reg[99])
                deriv_reg <= gket_pkg::sat_acc(deriv_reg, dpart_reg + prod);
            unique case (state_reg)
                ST_CLEAR: addr_reg <= addr_reg + 1'b1;
                ST_IDLE:
                begin
                    step_reg <= '0;
                    grp_reg <= '0;
                    elem_reg <= '0;
                    addr_reg <= '0;
                end
                ST_ACC: step_reg <= step_reg + 1'b1;
                ST_EMIT:
                begin
                    elem_reg <= elem_reg + 1'b1;
                    if (elem_reg < 4'd8)
                        addr_reg <= addr_reg + 1'b1;
                end
                ST_OUT:
                    if (m_axis_tready)
                    begin
                        elem_reg <= '0;
                        addr_reg <= addr_reg + 1'b1;
                        grp_reg <= grp_reg + 1'b1;
                        if (grp_reg + 1'b1 == eff)
                            deriv_reg <= '0;
                    end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during readout");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> grp_reg < eff) else $error("group beyond count");
`endif
endmodule
`default_nettype wire

// ===== dv/gket_checker.sv =====
// Checker: predicts group kinetic energy tensors and compares emitted results
`timescale 1ns / 1ps
`default_nettype none
module gket_checker
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_valid,
    input  wire          s_ready,
    input  wire  [151:0] s_data,
    input  wire          s_last,
    input  wire          m_valid,
    input  wire          m_ready,
    input  wire  [487:0] m_data,
    input  wire          m_last,
    input  wire          cfg_we,
    input  wire  [gket_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire  [gket_pkg::CfgDataW-1:0] cfg_data,
    output int           errors,
    output int           pending
);
    typedef struct packed {
        logic                             last;
        logic signed [gket_pkg::AccW-1:0] deriv;
        logic [9*gket_pkg::AccW-1:0]      tens;
        logic [2:0]                       grp;
    } tensor_result_t;

    logic signed [gket_pkg::AccW-1:0] tensor_acc [gket_pkg::MaxGroupsDefault*9];
    logic signed [gket_pkg::AccW-1:0] deriv_acc;
    logic [3:0]             n_groups;
    logic                   pert_on;
    tensor_result_t         tensor_q [$];

    // floor(a*b/2^25) then clamp the term and add with saturation
    function automatic logic signed [gket_pkg::AccW-1:0] acc_add(
        input logic signed [gket_pkg::AccW-1:0] acc,
        input logic signed [127:0] prod
    );
        logic signed [127:0] term;
        logic signed [127:0] s;
        begin
            term = prod >>> gket_pkg::ShiftK;
            if (term > 128'sh7FFFFFFFFFFF) term = 128'sh7FFFFFFFFFFF;
            if (term < -128'sh800000000000) term = -128'sh800000000000;
            s = term + 128'(acc);
            if (s > 128'sh7FFFFFFFFFFF) s = 128'sh7FFFFFFFFFFF;
            if (s < -128'sh800000000000) s = -128'sh800000000000;
            return s[gket_pkg::AccW-1:0];
        end
    endfunction

    task automatic absorb_atom(input logic [151:0] d, input logic lst);
        int unsigned cnt;
        logic [2:0] g;
        logic signed [127:0] v [3];
        logic signed [127:0] mass, dm, sq;
        tensor_result_t r;
        begin
            cnt = (n_groups == 0) ? 1 : (n_groups > gket_pkg::MaxGroupsDefault)
                ? gket_pkg::MaxGroupsDefault : n_groups;
            g = d[2:0];
            mass = 128'(d[26:3]);
            v[0] = 128'(signed'(d[50:27]));
            v[1] = 128'(signed'(d[74:51]));
            v[2] = 128'(signed'(d[98:75]));
            if (g < cnt)
                for (int m = 0; m < 3; m++)
                    for (int k = 0; k < 3; k++)
                        tensor_acc[g*9+m*3+k] = acc_add(tensor_acc[g*9+m*3+k],
                            mass * v[m] * v[k]);
            if (pert_on && d[99])
            begin
                dm = 128'(d[147:124]) - 128'(d[123:100]);
                sq = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
                deriv_acc = acc_add(deriv_acc, dm * sq);
            end
            if (lst)
            begin
                for (int k = 0; k < cnt; k++)
                begin
                    r.grp = k[2:0];
                    for (int e = 0; e < 9; e++)
                        r.tens[e*gket_pkg::AccW +: gket_pkg::AccW] = tensor_acc[k*9+e];
                    r.deriv = deriv_acc;
                    r.last = (k + 1 == cnt);
                    tensor_q.push_back(r);
                end
                foreach (tensor_acc[i]) tensor_acc[i] = '0;
                deriv_acc = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tensor_result_t want;
        if (!rst_n)
        begin
            foreach (tensor_acc[i]) tensor_acc[i] = '0;
            deriv_acc = '0;
            n_groups = 4'd1;
            pert_on = 1'b0;
            errors = 0;
            tensor_q.delete();
            pending = 0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                if (tensor_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result group %0d", $time, m_data[2:0]);
                end
                else
                begin
                    want = tensor_q.pop_front();
                    if (m_data[2:0] !== want.grp)
                    begin
                        errors++;
                        $display("%0t: group exp %0d got %0d", $time, want.grp, m_data[2:0]);
                    end
                    for (int e = 0; e < 9; e++)
                        if (m_data[3+e*gket_pkg::AccW +: gket_pkg::AccW]
                            !== want.tens[e*gket_pkg::AccW +: gket_pkg::AccW])
                        begin
                            errors++;
                            $display("%0t: grp %0d elem %0d exp %h got %h", $time, want.grp,
                                e, want.tens[e*gket_pkg::AccW +: gket_pkg::AccW],
                                m_data[3+e*gket_pkg::AccW +: gket_pkg::AccW]);
                        end
                    if (m_data[482:435] !== want.deriv)
                    begin
                        errors++;
                        $display("%0t: derivative exp %h got %h", $time, want.deriv,
                            m_data[482:435]);
                    end
                    if (m_last !== want.last)
                    begin
                        errors++;
                        $display("%0t: tlast exp %b got %b", $time, want.last, m_last);
                    end
                end
            end
            if (s_valid && s_ready)
                absorb_atom(s_data, s_last);
            if (cfg_we)
            begin
                if (cfg_index == gket_pkg::CFG_GROUP_COUNT) n_groups = cfg_data;
                else if (cfg_index == gket_pkg::CFG_MASS_PERT) pert_on = cfg_data[0];
            end
            pending = tensor_q.size();
        end
    end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench top: stimulus, receiver stalls and verdict for the tensor block
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [151:0]  s_axis_tdata;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [487:0]  m_axis_tdata;
    logic          m_axis_tlast;
    logic          cfg_we;
    logic [gket_pkg::CfgIdxW-1:0]  cfg_index;
    logic [gket_pkg::CfgDataW-1:0] cfg_data;
    int            errors;
    int            pending;
    int            idle_cycles;
    bit            no_idle;
    bit            long_hold;
    bit            timed_out;

    group_kinetic_energy_tensor u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gket_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
        .s_last(s_axis_tlast),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
        .m_last(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall bursts, one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [23:0] rnd_vel(input int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_atom(input logic [2:0] g, input logic [23:0] mass,
        input logic [23:0] vx, input logic [23:0] vy, input logic [23:0] vz,
        input logic pert, input logic [23:0] ma, input logic [23:0] mb, input logic lst);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, mb, ma, pert, vz, vy, vx, mass, g};
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_random_atom(input logic lst);
        send_atom(3'($urandom), $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom),
            rnd_vel($urandom_range(0, 5)), rnd_vel($urandom_range(0, 5)),
            rnd_vel($urandom_range(0, 5)), 1'($urandom), 24'($urandom), 24'($urandom), lst);
    endtask

    task automatic drain_then_config(input logic [gket_pkg::CfgIdxW-1:0] idx,
        input logic [gket_pkg::CfgDataW-1:0] val);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [gket_pkg::CfgDataW-1:0] counts [6];
        int sent;
        counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = gket_pkg::CFG_GROUP_COUNT;
        cfg_data = '0;
        no_idle = 1'b0;
        long_hold = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, perturbation on, dropped groups, big saturating sums
        drain_then_config(gket_pkg::CFG_MASS_PERT, 4'd1);
        drain_then_config(gket_pkg::CFG_GROUP_COUNT, 4'd8);
        send_atom(3'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, 24'h0, 24'h0, 1'b1);
        for (int i = 0; i < 8; i++)
            send_atom(3'(i), 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1,
                24'h0, 24'hFFFFFF, 1'b0);
        send_atom(3'd7, 24'hFFFFFF, 24'h800000, 24'h800000, 24'h800000, 1'b1,
            24'hFFFFFF, 24'h0, 1'b0);
        send_atom(3'd2, 24'h000100, 24'h010000, 24'hFF0000, 24'h000001, 1'b1,
            24'h000200, 24'h000100, 1'b1);
        drain_then_config(gket_pkg::CFG_GROUP_COUNT, 4'd2);
        send_atom(3'd5, 24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1,
            24'h0, 24'hFFFFFF, 1'b0);
        send_atom(3'd1, 24'h000301, 24'hFFFFFF, 24'h000003, 24'h7FFFFF, 1'b0,
            24'h0, 24'hFFFFFF, 1'b1);
        drain_then_config(gket_pkg::CFG_MASS_PERT, 4'd0);
        send_atom(3'd1, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1,
            24'h0, 24'hFFFFFF, 1'b1);

        // random phases across group counts and the perturbation switch
        sent = 0;
        foreach (counts[p])
        begin
            drain_then_config(gket_pkg::CFG_GROUP_COUNT, counts[p]);
            drain_then_config(gket_pkg::CFG_MASS_PERT, 4'(p % 2 == 0));
            if (p == 2) long_hold = 1'b1;
            if (p == 5) no_idle = 1'b1;
            for (int i = 0; i < 34; i++)
            begin
                send_random_atom(i % 6 == 5 || i == 33);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/gket_pkg.sv
design/gket_mac.sv
design/group_kinetic_energy_tensor.sv
dv/gket_checker.sv
dv/testbench.sv
